// ===== design/cmld_pkg.sv =====
package cmld_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNTS,
    PH_LIST0,
    PH_LIST1,
    PH_LIST2,
    PH_LIST3,
    PH_DONE
  } phase_t;

  localparam logic [2:0] KIND_EMPTY = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVER32    = 3'd1;
  localparam logic [2:0] ERR_NOT_MIN   = 3'd2;
  localparam logic [2:0] ERR_UNORDERED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
  localparam logic [2:0] ERR_INCONSIST = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  localparam logic [31:0] FLAG_PRIVATE     = 32'h0000_0002;
  localparam logic [31:0] FLAG_STATIC      = 32'h0000_0008;
  localparam logic [31:0] FLAG_NATIVE      = 32'h0000_0100;
  localparam logic [31:0] FLAG_ABSTRACT    = 32'h0000_0400;
  localparam logic [31:0] FLAG_CONSTRUCTOR = 32'h0001_0000;

  localparam logic [16:0] TABLE_LIMIT = 17'h1_0000;

  localparam logic CFG_FIELD_SIZE  = 1'b0;
  localparam logic CFG_METHOD_SIZE = 1'b1;

endpackage

// ===== design/class_member_list_decoder.sv =====
// Decodes a class member record presented one byte per request, checking each ULEB128 value
// and each member, and gives one result per member, one for a record with no members, or one
// error result that ends the record until the next start. A byte can be taken in every cycle
// while the result side is not stalled; its result, if any, is formed as the byte passes
// from the input register through one pass of decode logic into the output register. The
// user must write the table sizes through the configuration port only while no record is in
// flight; the block itself does not enforce this.
module class_member_list_decoder
  import cmld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_record,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_member_kind,
  output logic [15:0] out_member_index,
  output logic [31:0] out_access_flags,
  output logic [31:0] out_code_offset,
  output logic [2:0]  out_error_code,
  output logic        out_last_in_record
);

  logic [16:0] field_size_r;
  logic [16:0] method_size_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_eod_r;

  phase_t      phase_r, phase_c, phase_nxt;
  logic [31:0] cnt_r [4];
  logic [31:0] cnt_c [4];
  logic [31:0] cnt_nxt [4];
  logic [31:0] acc_r, acc_c, acc_nxt;
  logic [2:0]  pos_r, pos_c, pos_nxt;
  logic [1:0]  sub_r, sub_c, sub_nxt;
  logic [31:0] run_r, run_c, run_nxt;
  logic        first_r, first_c, first_nxt;
  logic [31:0] held_r, held_c, held_nxt;

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [15:0] index_r;
  logic [31:0] access_r;
  logic [31:0] code_r;
  logic [2:0]  err_r;
  logic        last_r;

  logic        out_ready;
  logic        s1_fire;

  logic        have;
  logic [2:0]  err;
  logic [2:0]  res_kind;
  logic [15:0] res_index;
  logic [31:0] res_access;
  logic [31:0] res_code;
  logic        res_last;

  logic        active;
  logic [1:0]  lst;
  logic [2:0]  kind_now;
  logic        complete;
  logic [31:0] val;
  logic [31:0] shifted;
  logic [31:0] acc_sum;
  logic [32:0] sum33;
  logic [16:0] field_eff;
  logic [16:0] method_eff;
  logic        found;
  logic [1:0]  next_lst;
  logic        direct_set;
  logic        no_code;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  assign field_eff  = field_size_r[16] ? TABLE_LIMIT : field_size_r;
  assign method_eff = method_size_r[16] ? TABLE_LIMIT : method_size_r;

  always_comb begin
    if (s1_start_r) begin
      phase_c = PH_COUNTS;
      for (int i = 0; i < 4; i++) begin
        cnt_c[i] = '0;
      end
      acc_c   = '0;
      pos_c   = '0;
      sub_c   = '0;
      run_c   = '0;
      first_c = 1'b1;
      held_c  = '0;
    end else begin
      phase_c = phase_r;
      cnt_c   = cnt_r;
      acc_c   = acc_r;
      pos_c   = pos_r;
      sub_c   = sub_r;
      run_c   = run_r;
      first_c = first_r;
      held_c  = held_r;
    end
  end

  always_comb begin
    case (phase_c)
      PH_LIST0: begin
        active = 1'b1;
        lst    = 2'd0;
      end
      PH_LIST1: begin
        active = 1'b1;
        lst    = 2'd1;
      end
      PH_LIST2: begin
        active = 1'b1;
        lst    = 2'd2;
      end
      PH_LIST3: begin
        active = 1'b1;
        lst    = 2'd3;
      end
      PH_COUNTS: begin
        active = 1'b1;
        lst    = 2'd0;
      end
      default: begin
        active = 1'b0;
        lst    = 2'd0;
      end
    endcase
  end

  always_comb begin
    case (pos_c)
      3'd0:    shifted = {25'b0, s1_byte_r[6:0]};
      3'd1:    shifted = {18'b0, s1_byte_r[6:0], 7'b0};
      3'd2:    shifted = {11'b0, s1_byte_r[6:0], 14'b0};
      3'd3:    shifted = {4'b0, s1_byte_r[6:0], 21'b0};
      default: shifted = {s1_byte_r[3:0], 28'b0};
    endcase
  end

  assign acc_sum = acc_c | shifted;

  function automatic phase_t list_phase(input logic [1:0] l);
    phase_t p;
    case (l)
      2'd0:    p = PH_LIST0;
      2'd1:    p = PH_LIST1;
      2'd2:    p = PH_LIST2;
      default: p = PH_LIST3;
    endcase
    return p;
  endfunction

  always_comb begin
    phase_nxt = phase_c;
    cnt_nxt   = cnt_c;
    acc_nxt   = acc_c;
    pos_nxt   = pos_c;
    sub_nxt   = sub_c;
    run_nxt   = run_c;
    first_nxt = first_c;
    held_nxt  = held_c;

    have       = 1'b0;
    err        = ERR_NONE;
    res_kind   = '0;
    res_index  = '0;
    res_access = '0;
    res_code   = '0;
    res_last   = 1'b0;
    complete   = 1'b0;
    val        = '0;
    found      = 1'b0;
    next_lst   = '0;
    direct_set = (held_c & (FLAG_PRIVATE | FLAG_STATIC | FLAG_CONSTRUCTOR)) != '0;
    no_code    = (held_c & (FLAG_NATIVE | FLAG_ABSTRACT)) != '0;
    kind_now   = (phase_c == PH_COUNTS) ? KIND_EMPTY : {1'b0, lst};
    sum33      = '0;

    if (active) begin
      if (pos_c >= 3'd4 && s1_byte_r[7:4] != 4'd0) begin
        err = ERR_OVER32;
      end else if (!s1_byte_r[7]) begin
        if (pos_c != 3'd0 && s1_byte_r == 8'd0) begin
          err = ERR_NOT_MIN;
        end else begin
          complete = 1'b1;
          val      = acc_sum;
          acc_nxt  = '0;
          pos_nxt  = '0;
        end
      end else begin
        acc_nxt = acc_sum;
        pos_nxt = pos_c + 3'd1;
      end

      if (complete && phase_c == PH_COUNTS) begin
        cnt_nxt[sub_c] = val;
        if (sub_c == 2'd3) begin
          sub_nxt   = '0;
          run_nxt   = '0;
          first_nxt = 1'b1;
          for (int j = 0; j < 4; j++) begin
            if (!found && cnt_nxt[j] != '0) begin
              found    = 1'b1;
              next_lst = 2'(j);
            end
          end
          if (found) begin
            phase_nxt = list_phase(next_lst);
          end else begin
            phase_nxt = PH_DONE;
            have      = 1'b1;
            res_kind  = KIND_EMPTY;
            res_last  = 1'b1;
          end
        end else begin
          sub_nxt = sub_c + 2'd1;
        end
      end else if (complete) begin
        sum33 = {1'b0, run_c} + {1'b0, val};
        if (sub_c == 2'd0) begin
          if (!first_c && val == '0) begin
            err = ERR_UNORDERED;
          end else if (sum33[32]) begin
            err = ERR_OVERFLOW;
          end else begin
            run_nxt   = sum33[31:0];
            first_nxt = 1'b0;
            sub_nxt   = 2'd1;
          end
        end else if (sub_c == 2'd1 && !lst[1]) begin
          if (run_c >= {15'b0, field_eff} ||
              ((val & FLAG_STATIC) != '0) != (lst == 2'd0)) begin
            err = ERR_INCONSIST;
          end else begin
            have       = 1'b1;
            res_access = val;
          end
        end else if (sub_c == 2'd1) begin
          held_nxt = val;
          sub_nxt  = 2'd2;
        end else begin
          if (run_c >= {15'b0, method_eff} || direct_set != (lst == 2'd2) ||
              (val == '0) != no_code) begin
            err = ERR_INCONSIST;
          end else begin
            have       = 1'b1;
            res_access = held_c;
            res_code   = val;
          end
        end

        if (have) begin
          res_kind     = {1'b0, lst};
          res_index    = run_c[15:0];
          cnt_nxt[lst] = cnt_c[lst] - 32'd1;
          sub_nxt      = '0;
          for (int j = 0; j < 4; j++) begin
            if (!found && 2'(j) >= lst && cnt_nxt[j] != '0) begin
              found    = 1'b1;
              next_lst = 2'(j);
            end
          end
          if (!found) begin
            phase_nxt = PH_DONE;
            res_last  = 1'b1;
          end else begin
            phase_nxt = list_phase(next_lst);
            if (next_lst != lst) begin
              run_nxt   = '0;
              first_nxt = 1'b1;
            end
          end
        end
      end

      if (err == ERR_NONE && s1_eod_r && phase_nxt != PH_DONE) begin
        err = ERR_TRUNCATED;
      end
      if (err != ERR_NONE) begin
        phase_nxt  = PH_DONE;
        have       = 1'b1;
        res_kind   = kind_now;
        res_index  = '0;
        res_access = '0;
        res_code   = '0;
        res_last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_size_r  <= '0;
      method_size_r <= '0;
      s1_valid_r    <= 1'b0;
      phase_r       <= PH_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FIELD_SIZE) begin
          field_size_r <= cfg_wdata;
        end
        if (cfg_index == CFG_METHOD_SIZE) begin
          method_size_r <= cfg_wdata;
        end
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        phase_r     <= phase_nxt;
        out_valid_r <= have;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_byte_value;
      s1_start_r <= in_start_record;
      s1_eod_r   <= in_end_of_data;
    end
    if (s1_fire) begin
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      sub_r   <= sub_nxt;
      run_r   <= run_nxt;
      first_r <= first_nxt;
      held_r  <= held_nxt;
      if (have) begin
        kind_r   <= res_kind;
        index_r  <= res_index;
        access_r <= res_access;
        code_r   <= res_code;
        err_r    <= err;
        last_r   <= res_last;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_member_kind    = kind_r;
  assign out_member_index   = index_r;
  assign out_access_flags   = access_r;
  assign out_code_offset    = code_r;
  assign out_error_code     = err_r;
  assign out_last_in_record = last_r;

endmodule
